[sv/pvd_pkg.sv]
// Package for the prefix-length varint decoder.
// Holds prefix byte thresholds and result status codes; no dependencies.
package pvd_pkg;

  localparam logic [7:0] PREFIX_2B      = 8'h80;
  localparam logic [7:0] PREFIX_3B      = 8'hC0;
  localparam logic [7:0] PREFIX_4B      = 8'hE0;
  localparam logic [7:0] PREFIX_5B      = 8'hF0;
  localparam logic [7:0] PREFIX_TOO_BIG = 8'hF1;

  localparam int unsigned VALUE_W = 31;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ACC_W = 32;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_TOO_BIG  = 2'd1;
  localparam status_t ST_NEGATIVE = 2'd2;

endpackage

[sv/prefix_varint_decoder.sv]
// Top level of the prefix-length varint decoder; depends on pvd_pkg.
// One byte per transfer in, one decoded number per completed prefix code out.
// The result is registered at the transfer of a number's last byte and can
// be taken in the next cycle. Throughput: one byte per cycle; input
// stalls only while the output register is full and not being taken.
// Reset: synchronous; clears decode state and the output valid.
module prefix_varint_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pvd_pkg::VALUE_W-1:0]   value,
  output logic [pvd_pkg::COUNT_W-1:0]   byte_count,
  output pvd_pkg::status_t              status
);

  logic [2:0]                  bytes_remaining, bytes_remaining_next;
  logic [pvd_pkg::ACC_W-1:0]   accumulator, accumulator_next;
  logic [pvd_pkg::ACC_W-1:0]   acc_shift;
  logic [2:0]                  length_so_far, length_so_far_next;
  logic                        fire;
  logic                        res_valid;
  logic [pvd_pkg::VALUE_W-1:0] res_value;
  logic [pvd_pkg::COUNT_W-1:0] res_count;
  pvd_pkg::status_t            res_status;

  assign in_ready  = !out_valid || out_ready;
  assign fire      = in_valid && in_ready;
  assign acc_shift = {accumulator[pvd_pkg::ACC_W-9:0], in_byte};

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    accumulator_next     = accumulator;
    length_so_far_next   = length_so_far;
    res_valid            = 1'b0;
    res_value            = '0;
    res_count            = 3'd1;
    res_status           = pvd_pkg::ST_OK;
    if (bytes_remaining == 3'd0) begin
      priority if (in_byte < pvd_pkg::PREFIX_2B) begin
        res_valid = 1'b1;
        res_value = {{(pvd_pkg::VALUE_W-8){1'b0}}, in_byte};
      end else if (in_byte >= pvd_pkg::PREFIX_TOO_BIG) begin
        res_valid          = 1'b1;
        res_status         = pvd_pkg::ST_TOO_BIG;
        accumulator_next   = '0;
        length_so_far_next = 3'd0;
      end else begin
        length_so_far_next = 3'd1;
        priority if (in_byte < pvd_pkg::PREFIX_3B) begin
          accumulator_next     = {{(pvd_pkg::ACC_W-6){1'b0}}, in_byte[5:0]};
          bytes_remaining_next = 3'd1;
        end else if (in_byte < pvd_pkg::PREFIX_4B) begin
          accumulator_next     = {{(pvd_pkg::ACC_W-5){1'b0}}, in_byte[4:0]};
          bytes_remaining_next = 3'd2;
        end else if (in_byte < pvd_pkg::PREFIX_5B) begin
          accumulator_next     = {{(pvd_pkg::ACC_W-4){1'b0}}, in_byte[3:0]};
          bytes_remaining_next = 3'd3;
        end else begin
          accumulator_next     = '0;
          bytes_remaining_next = 3'd4;
        end
      end
    end else begin
      accumulator_next     = acc_shift;
      bytes_remaining_next = bytes_remaining - 3'd1;
      length_so_far_next   = length_so_far + 3'd1;
      if (bytes_remaining == 3'd1) begin
        res_valid          = 1'b1;
        res_count          = length_so_far + 3'd1;
        accumulator_next   = '0;
        length_so_far_next = 3'd0;
        if (acc_shift[pvd_pkg::ACC_W-1]) begin
          res_status = pvd_pkg::ST_NEGATIVE;
        end else begin
          res_value = acc_shift[pvd_pkg::VALUE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 3'd0;
      accumulator     <= '0;
      length_so_far   <= 3'd0;
    end else if (fire) begin
      bytes_remaining <= bytes_remaining_next;
      accumulator     <= accumulator_next;
      length_so_far   <= length_so_far_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      value      <= res_value;
      byte_count <= res_count;
      status     <= res_status;
    end
  end

endmodule

[test/prefix_varint_decoder_tb.sv]
// Testbench for prefix_varint_decoder: drives directed and random byte streams with random
// idling on both sides and checks each decoded number against a local predictor.
// Depends on pvd_pkg and the prefix_varint_decoder RTL.
module prefix_varint_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [pvd_pkg::VALUE_W-1:0] value;
    logic [pvd_pkg::COUNT_W-1:0] count;
    pvd_pkg::status_t            status;
  } number_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [7:0]                    in_byte;
  logic                          out_valid;
  logic                          out_ready;
  logic [pvd_pkg::VALUE_W-1:0]   value;
  logic [pvd_pkg::COUNT_W-1:0]   byte_count;
  pvd_pkg::status_t              status;

  number_t                       pending_numbers[$];
  logic [2:0]                    dec_left;
  logic [pvd_pkg::ACC_W-1:0]     dec_acc;
  logic [2:0]                    dec_len;
  bit                            idle_on;
  int unsigned                   items_sent;
  int unsigned                   error_count;
  int unsigned                   cycle_count;
  int unsigned                   stall_left;

  prefix_varint_decoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .byte_count (byte_count),
    .status     (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic void push_number(logic [pvd_pkg::VALUE_W-1:0] v,
                                      logic [pvd_pkg::COUNT_W-1:0] c,
                                      pvd_pkg::status_t s);
    number_t num;
    num.value = v;
    num.count = c;
    num.status = s;
    pending_numbers.push_back(num);
  endfunction

  // Advance the decode state by one byte; queue a number when one completes.
  function automatic void decode_byte(logic [7:0] b);
    if (dec_left == 3'd0) begin
      if (b < pvd_pkg::PREFIX_2B) begin
        push_number({24'd0, b[6:0]}, 3'd1, pvd_pkg::ST_OK);
      end else if (b >= pvd_pkg::PREFIX_TOO_BIG) begin
        dec_acc = '0;
        dec_len = 3'd0;
        push_number('0, 3'd1, pvd_pkg::ST_TOO_BIG);
      end else begin
        dec_len = 3'd1;
        if (b < pvd_pkg::PREFIX_3B) begin
          dec_acc = {24'd0, b - pvd_pkg::PREFIX_2B};
          dec_left = 3'd1;
        end else if (b < pvd_pkg::PREFIX_4B) begin
          dec_acc = {24'd0, b - pvd_pkg::PREFIX_3B};
          dec_left = 3'd2;
        end else if (b < pvd_pkg::PREFIX_5B) begin
          dec_acc = {24'd0, b - pvd_pkg::PREFIX_4B};
          dec_left = 3'd3;
        end else begin
          dec_acc = '0;
          dec_left = 3'd4;
        end
      end
    end else begin
      dec_acc = {dec_acc[pvd_pkg::ACC_W-9:0], b};
      dec_left = dec_left - 3'd1;
      dec_len = dec_len + 3'd1;
      if (dec_left == 3'd0) begin
        if (dec_acc[pvd_pkg::ACC_W-1]) push_number('0, dec_len, pvd_pkg::ST_NEGATIVE);
        else push_number(dec_acc[pvd_pkg::VALUE_W-1:0], dec_len, pvd_pkg::ST_OK);
        dec_acc = '0;
        dec_len = 3'd0;
      end
    end
  endfunction

  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    decode_byte(b);
    items_sent++;
  endtask

  task automatic send_number(int unsigned nbytes, logic [31:0] payload);
    case (nbytes)
      1: send_byte({1'b0, payload[6:0]});
      2: send_byte(pvd_pkg::PREFIX_2B | {2'b00, payload[13:8]});
      3: send_byte(pvd_pkg::PREFIX_3B | {3'b000, payload[20:16]});
      4: send_byte(pvd_pkg::PREFIX_4B | {4'h0, payload[27:24]});
      default: send_byte(pvd_pkg::PREFIX_5B);
    endcase
    for (int i = int'(nbytes) - 2; i >= 0; i--) send_byte(payload[8*i +: 8]);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_numbers.size() != 0) @(posedge clk);
  endtask

  // Receiver: draw a stall per result, check each transfer.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_numbers.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d count=%0d status=%0d",
                                  value, byte_count, status));
      end else begin
        number_t exp_num;
        exp_num = pending_numbers.pop_front();
        if (value !== exp_num.value)
          report_mismatch($sformatf("value %0d, expected %0d", value, exp_num.value));
        if (byte_count !== exp_num.count)
          report_mismatch($sformatf("byte_count %0d, expected %0d", byte_count,
                                    exp_num.count));
        if (status !== exp_num.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, exp_num.status));
      end
      stall_left = idle_on ? $urandom_range(0, 6) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_ready <= (stall_left == 0);
  end

  task automatic test_single_byte_values();
    send_byte(8'h00);
    send_byte(8'h7F);
  endtask

  task automatic test_too_big_prefix();
    send_byte(pvd_pkg::PREFIX_TOO_BIG);
    send_byte(8'hFF);
  endtask

  task automatic test_multi_byte_extremes();
    send_number(2, 32'h0000_0000);
    send_number(2, 32'h0000_3FFF);
    send_number(3, 32'h001F_FFFF);
    send_number(4, 32'h0FFF_FFFF);
    send_number(5, 32'h7FFF_FFFF);
  endtask

  task automatic test_negative_value();
    send_number(5, 32'h8000_0000);
  endtask

  task automatic test_random_stream(int unsigned n_items);
    int unsigned target;
    int unsigned kind;
    logic [31:0] payload;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 49) == 0) idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 4) begin
        send_byte(8'($urandom_range(pvd_pkg::PREFIX_TOO_BIG, 8'hFF)));
      end else begin
        payload = $urandom;
        case ($urandom_range(0, 7))
          0: payload = '0;
          1: payload = '1;
          2: payload = 32'h7FFF_FFFF;
          default: ;
        endcase
        send_number($urandom_range(1, 5), payload);
      end
    end
  endtask

  task automatic test_drain_pause();
    idle_on = 1'b1;
    repeat (4) begin
      repeat (6) send_number($urandom_range(1, 5), $urandom);
      wait_results_drained();
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_byte <= 8'h00;
    out_ready <= 1'b0;
    dec_left = '0;
    dec_acc = '0;
    dec_len = '0;
    idle_on = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_byte_values();
    test_too_big_prefix();
    test_multi_byte_extremes();
    test_negative_value();
    test_random_stream(900);
    test_drain_pause();
    test_random_stream(900);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_numbers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
